// ===== src/cfbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfbf_pkg
// Shared widths, operation codes and controller interface types for the
// chaptered byte FIFO.
// ----------------------------------------------------------------------------
package cfbf_pkg;

  // Default depths of the two rings.
  localparam int DEF_DATA_DEPTH   = 64;
  localparam int DEF_RECORD_DEPTH = 16;

  // Field widths of the stream payloads.
  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 5;
  localparam int LEN_W   = 7;
  localparam int CHAP_W  = 5;
  localparam int FREE_W  = 7;
  localparam int RFREE_W = 5;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_USED_W  = BYTE_W + LEN_W + LEN_W + CHAP_W + FREE_W + RFREE_W;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 3'd0,
    OP_END    = 3'd1,
    OP_RBYTE  = 3'd2,
    OP_RCHAP  = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic do_write;
    logic do_end;
    logic do_rbyte;
    logic do_rchap;
    logic del_start;
    logic del_issue;
    logic del_finish;
    logic stream_issue;
    logic set_err;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic wr_ok;
    logic end_ok;
    logic head_nz;
    logic del_ok;
    logic del_left_zero;
    logic stream_more;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/cfbf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfbf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cfbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/cfbf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfbf_ctrl
// Sequencer: takes one operation at a time, steps the datapath through it
// and hands each result to the output register.
// ----------------------------------------------------------------------------
module cfbf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire cfbf_pkg::stat_t stat,
  output cfbf_pkg::cmd_t       cmd
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_DECODE  = 8'b0000_0010,
    ST_LOAD    = 8'b0000_0100,
    ST_DEL     = 8'b0000_1000,
    ST_DEL_FIN = 8'b0001_0000,
    ST_STREAM  = 8'b0010_0000,
    ST_SWAIT   = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_EMIT;
        case (stat.op)
          cfbf_pkg::OP_WRITE: begin
            cmd.do_write = stat.wr_ok;
            cmd.set_err  = !stat.wr_ok;
          end
          cfbf_pkg::OP_END: begin
            cmd.do_end  = stat.end_ok;
            cmd.set_err = !stat.end_ok;
          end
          cfbf_pkg::OP_RBYTE: begin
            cmd.do_rbyte = stat.head_nz;
            cmd.set_err  = !stat.head_nz;
            if (stat.head_nz) begin
              state_nxt = ST_LOAD;
            end
          end
          cfbf_pkg::OP_RCHAP: begin
            cmd.do_rchap = stat.head_nz;
            cmd.set_err  = !stat.head_nz;
            if (stat.head_nz) begin
              state_nxt = ST_LOAD;
            end
          end
          cfbf_pkg::OP_DELETE: begin
            cmd.del_start = stat.del_ok;
            cmd.set_err   = !stat.del_ok;
            if (stat.del_ok) begin
              state_nxt = ST_DEL;
            end
          end
          default: begin
            cmd.set_err = 1'b1;
          end
        endcase
      end
      ST_LOAD: begin
        // The next head length lands from the length ring during this cycle.
        state_nxt = stat.stream_more ? ST_STREAM : ST_EMIT;
      end
      ST_DEL: begin
        if (stat.del_left_zero) begin
          state_nxt = ST_DEL_FIN;
        end else begin
          cmd.del_issue = 1'b1;
        end
      end
      ST_DEL_FIN: begin
        cmd.del_finish = 1'b1;
        state_nxt      = ST_LOAD;
      end
      ST_STREAM: begin
        cmd.stream_issue = 1'b1;
        state_nxt        = ST_SWAIT;
      end
      ST_SWAIT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.stream_more ? ST_STREAM : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DECODE))
    else $error("accepted transfer did not move the controller to decode");
`endif

endmodule
`default_nettype wire

// ===== src/cfbf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfbf_dp
// Datapath: data ring, length ring, occupancy counters, head and tail
// chapter lengths, delete accumulator and the result register.
// ----------------------------------------------------------------------------
module cfbf_dp #(
  parameter int DATA_DEPTH   = cfbf_pkg::DEF_DATA_DEPTH,
  parameter int RECORD_DEPTH = cfbf_pkg::DEF_RECORD_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [cfbf_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [cfbf_pkg::OP_W-1:0]        in_tuser,
  input  wire logic                             out_tready,
  output logic                                  out_tvalid,
  output logic      [cfbf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  input  wire cfbf_pkg::cmd_t                   cmd,
  output cfbf_pkg::stat_t                       stat
);

  localparam int DPW  = $clog2(DATA_DEPTH);
  localparam int UW   = $clog2(DATA_DEPTH + 1);
  localparam int SW   = UW + 1;
  localparam int RPW  = $clog2(RECORD_DEPTH);
  localparam int RUW  = $clog2(RECORD_DEPTH + 1);
  localparam int CHW  = $clog2(RECORD_DEPTH + 2);
  localparam int CMPW = (CHW > cfbf_pkg::CNT_W) ? CHW : cfbf_pkg::CNT_W;

  // Latched operation.
  cfbf_pkg::op_t               op_r;
  logic [cfbf_pkg::BYTE_W-1:0] din_r;
  logic [cfbf_pkg::CNT_W-1:0]  cnt_r;

  // Ring state.
  logic [DPW-1:0] rptr_r, wptr_r, sptr_r;
  logic [UW-1:0]  used_r;
  logic [RPW-1:0] lrptr_r, lwptr_r;
  logic [RUW-1:0] lused_r;
  logic [UW-1:0]  head_r, tail_r;
  logic           no_head_r;

  // Per-operation working registers.
  logic                        err_r;
  logic [cfbf_pkg::BYTE_W-1:0] byte_r;
  logic [UW-1:0]               clen_r;
  logic [UW-1:0]               stream_left_r;
  logic [UW-1:0]               total_r;
  logic [cfbf_pkg::CNT_W-1:0]  del_left_r;
  logic                        d_rd_pend_r, load_pend_r, acc_pend_r;

  // Result register.
  logic                         out_valid_r;
  logic                         out_status_r;
  logic                         out_last_r;
  logic [cfbf_pkg::OUT_USED_W-1:0] out_payload_r;

  // RAM ports.
  logic                        d_wr_en, d_rd_en;
  logic [DPW-1:0]              d_rd_addr;
  logic [cfbf_pkg::BYTE_W-1:0] d_rd_data;
  logic                        l_wr_en, l_rd_en;
  logic [UW-1:0]               l_rd_data;

  logic           head_empties, next_head_rd, next_head_none;
  logic [CHW-1:0] chapters;
  logic [UW-1:0]  total_cap, adv_amt, used_sub;
  logic [SW-1:0]  adv_sum, adv_wrap;

  function automatic logic [DPW-1:0] dp_inc(input logic [DPW-1:0] p);
    return (p == DPW'(DATA_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RPW-1:0] lp_inc(input logic [RPW-1:0] p);
    return (p == RPW'(RECORD_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign chapters = CHW'(lused_r) + CHW'(head_r != '0);

  assign stat.op            = op_r;
  assign stat.wr_ok         = (lused_r != RUW'(RECORD_DEPTH)) && (used_r != UW'(DATA_DEPTH));
  assign stat.end_ok        = (tail_r != '0) && (lused_r != RUW'(RECORD_DEPTH));
  assign stat.head_nz       = (head_r != '0);
  assign stat.del_ok        = (cnt_r != '0) && (CMPW'(cnt_r) <= CMPW'(chapters));
  assign stat.del_left_zero = (del_left_r == '0);
  assign stat.stream_more   = (stream_left_r != '0);
  assign stat.out_busy      = out_valid_r && !out_tready;

  // When the head chapter runs out, the next queued length becomes the head.
  assign head_empties   = (cmd.do_rbyte && (head_r == UW'(1))) || cmd.do_rchap
                          || cmd.del_finish;
  assign next_head_rd   = head_empties && (lused_r != '0);
  assign next_head_none = head_empties && (lused_r == '0);

  assign total_cap = (total_r > used_r) ? used_r : total_r;
  assign adv_amt   = cmd.do_rchap ? head_r : total_cap;
  assign adv_sum   = SW'(rptr_r) + SW'(adv_amt);
  assign adv_wrap  = (adv_sum >= SW'(DATA_DEPTH)) ? adv_sum - SW'(DATA_DEPTH) : adv_sum;

  always_comb begin
    used_sub = '0;
    if (cmd.do_rbyte) begin
      used_sub = UW'(1);
    end else if (cmd.do_rchap || cmd.del_finish) begin
      used_sub = adv_amt;
    end
  end

  assign d_wr_en   = cmd.do_write;
  assign d_rd_en   = cmd.do_rbyte || cmd.stream_issue;
  assign d_rd_addr = cmd.stream_issue ? sptr_r : rptr_r;
  assign l_wr_en   = cmd.do_end && !no_head_r;
  assign l_rd_en   = next_head_rd || cmd.del_issue;

  cfbf_ram #(
    .WIDTH (cfbf_pkg::BYTE_W),
    .DEPTH (DATA_DEPTH)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (d_wr_en),
    .wr_addr (wptr_r),
    .wr_data (din_r),
    .rd_en   (d_rd_en),
    .rd_addr (d_rd_addr),
    .rd_data (d_rd_data)
  );

  cfbf_ram #(
    .WIDTH (UW),
    .DEPTH (RECORD_DEPTH)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (l_wr_en),
    .wr_addr (lwptr_r),
    .wr_data (tail_r),
    .rd_en   (l_rd_en),
    .rd_addr (lrptr_r),
    .rd_data (l_rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r        <= '0;
      wptr_r        <= '0;
      used_r        <= '0;
      lrptr_r       <= '0;
      lwptr_r       <= '0;
      lused_r       <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      no_head_r     <= 1'b1;
      d_rd_pend_r   <= 1'b0;
      load_pend_r   <= 1'b0;
      acc_pend_r    <= 1'b0;
      stream_left_r <= '0;
      del_left_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      d_rd_pend_r <= d_rd_en;
      load_pend_r <= next_head_rd;
      acc_pend_r  <= cmd.del_issue;

      if (cmd.do_write) begin
        wptr_r <= dp_inc(wptr_r);
        used_r <= used_r + 1'b1;
        tail_r <= tail_r + 1'b1;
      end else begin
        used_r <= used_r - used_sub;
      end

      if (cmd.do_rbyte) begin
        rptr_r <= dp_inc(rptr_r);
      end else if (cmd.do_rchap || cmd.del_finish) begin
        rptr_r <= adv_wrap[DPW-1:0];
      end

      if (cmd.do_end) begin
        tail_r <= '0;
        if (no_head_r) begin
          head_r    <= tail_r;
          no_head_r <= 1'b0;
        end else begin
          lwptr_r <= lp_inc(lwptr_r);
          lused_r <= lused_r + 1'b1;
        end
      end else if (l_rd_en) begin
        lrptr_r <= lp_inc(lrptr_r);
        lused_r <= lused_r - 1'b1;
      end

      if (cmd.do_rbyte) begin
        head_r <= head_r - 1'b1;
      end else if (cmd.do_rchap || cmd.del_finish) begin
        head_r <= '0;
      end else if (load_pend_r) begin
        head_r <= l_rd_data;
      end
      if (next_head_none) begin
        no_head_r <= 1'b1;
      end

      if (cmd.latch_in) begin
        stream_left_r <= '0;
      end else if (cmd.do_rchap) begin
        stream_left_r <= head_r;
      end else if (cmd.stream_issue) begin
        stream_left_r <= stream_left_r - 1'b1;
      end

      if (cmd.del_start) begin
        del_left_r <= cnt_r - 1'b1;
      end else if (cmd.del_issue) begin
        del_left_r <= del_left_r - 1'b1;
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r   <= cfbf_pkg::op_t'(in_tuser);
      din_r  <= in_tdata[cfbf_pkg::BYTE_W-1:0];
      cnt_r  <= in_tdata[cfbf_pkg::BYTE_W +: cfbf_pkg::CNT_W];
      err_r  <= 1'b0;
      byte_r <= '0;
      clen_r <= '0;
    end else begin
      if (cmd.set_err) begin
        err_r <= 1'b1;
      end
      if (d_rd_pend_r) begin
        byte_r <= d_rd_data;
      end
      if (cmd.do_rchap) begin
        clen_r <= head_r;
      end
    end

    if (cmd.do_rchap) begin
      sptr_r <= rptr_r;
    end else if (cmd.stream_issue) begin
      sptr_r <= dp_inc(sptr_r);
    end

    if (cmd.del_start) begin
      total_r <= head_r;
    end else if (acc_pend_r) begin
      total_r <= total_r + l_rd_data;
    end

    if (cmd.emit) begin
      out_status_r  <= err_r;
      out_last_r    <= (stream_left_r == '0);
      out_payload_r <= {cfbf_pkg::RFREE_W'(RUW'(RECORD_DEPTH) - lused_r),
                        cfbf_pkg::FREE_W'(UW'(DATA_DEPTH) - used_r),
                        cfbf_pkg::CHAP_W'(chapters),
                        cfbf_pkg::LEN_W'(head_r),
                        cfbf_pkg::LEN_W'(clen_r),
                        byte_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = cfbf_pkg::OUT_TDATA_W'(out_payload_r);

`ifndef SYNTHESIS
  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !load_pend_r |-> (no_head_r == (head_r == '0)))
    else $error("head flag disagrees with head length");
  a_head_stored: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= used_r)
    else $error("head chapter longer than stored data");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_tready))
    else $error("result register overwritten before transfer");
`endif

endmodule
`default_nettype wire

// ===== src/chaptered_byte_fifo_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chaptered_byte_fifo_core
// Byte FIFO divided into chapters by a queue of chapter lengths.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one operation per transfer: in_tuser selects the
//   operation (write byte, end chapter, read byte, read chapter, delete
//   chapters), in_tdata carries the byte and the delete count. The out_
//   channel returns one result per operation, or one per byte for a chapter
//   read, with out_tlast on the final result of the operation.
//   Operations are taken one at a time. Write, end chapter and refused
//   operations go through the decode and emit states and present their result
//   in the output register. A byte read goes through decode, load and emit.
//   A chapter read goes through decode and load, then stream, wait and emit
//   once per byte, since each byte goes through the registered data RAM read
//   port. A delete of C chapters goes through decode, delete, delete finish,
//   load and emit, with one length RAM read per chapter beyond the head.
//   Reset clears the ring pointers and the counters; no clearing pass is needed, so
//   the block takes a transfer on the first cycle after reset.
//   Results wait in an output register; when the receiver stalls the block
//   may still take the next operation and holds its first result until the
//   register is free.
// ----------------------------------------------------------------------------
module chaptered_byte_fifo_core #(
  parameter int DATA_DEPTH   = cfbf_pkg::DEF_DATA_DEPTH,
  parameter int RECORD_DEPTH = cfbf_pkg::DEF_RECORD_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [7:0] data_in, [12:8] delete_count, [15:13] zero
  input  wire logic [cfbf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] op
  input  wire logic [cfbf_pkg::OP_W-1:0]        in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] data_out, [14:8] chapter_length, [21:15] head_length,
  // [26:22] chapter_count, [33:27] data_free, [38:34] record_free, [39] zero
  output logic      [cfbf_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] status
  output logic                                  out_tuser,
  output logic                                  out_tlast
);

  cfbf_pkg::cmd_t  cmd;
  cfbf_pkg::stat_t stat;

  cfbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cfbf_dp #(
    .DATA_DEPTH   (DATA_DEPTH),
    .RECORD_DEPTH (RECORD_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the chaptered byte FIFO. Operations are sent on the
// in_ channel, and every result on the out_ channel is compared field by
// field with a predictor that tracks the data ring, the length ring and the
// head chapter, or with a pinned row's typed-in result. A short directed
// table opens the run, followed by random chapter writes, reads, deletes and
// malformed operations, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import cfbf_pkg::*;

  localparam int DEPTH        = DEF_DATA_DEPTH;
  localparam int RDEPTH       = DEF_RECORD_DEPTH;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int RPTR_W       = $clog2(RDEPTH);
  localparam int MAX_BURST    = 64;
  localparam int RANDOM_ITEMS = 255;
  localparam int CYCLE_LIMIT  = 5000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_ROWS       = 25;

  // Codes above OP_DELETE are not defined and must be refused.
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic               status;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [LEN_W-1:0]   chap_len;
    logic [LEN_W-1:0]   head_len;
    logic [CHAP_W-1:0]  chap_cnt;
    logic [FREE_W-1:0]  data_free;
    logic [RFREE_W-1:0] rec_free;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] din;
    logic [CNT_W-1:0]  cnt;
    logic              pinned;
    result_t           want;
  } drow_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  chaptered_byte_fifo_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the two rings and the chapter bookkeeping.
  logic [BYTE_W-1:0] byte_ring [DEPTH];
  logic [PTR_W-1:0]  byte_rd, byte_wr;
  logic [LEN_W-1:0]  bytes_used;
  logic [LEN_W-1:0]  len_ring [RDEPTH];
  logic [RPTR_W-1:0] len_rd, len_wr;
  logic [CHAP_W-1:0] lens_used;
  logic [LEN_W-1:0]  head_left;
  logic [LEN_W-1:0]  tail_len;
  logic              no_head;

  result_t step_results[$];
  result_t due_results[$];
  drow_t   plan [N_ROWS];
  int      mismatches = 0;
  int      sent_items = 0;
  int      cycles = 0;

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int stored_chapters();
    return int'(lens_used) + (head_left != 0 ? 1 : 0);
  endfunction

  function automatic logic [LEN_W-1:0] pop_length();
    logic [LEN_W-1:0] v;
    v = '0;
    if (lens_used != 0) begin
      v = len_ring[len_rd];
      len_rd = len_rd + 1'b1;
      lens_used = lens_used - 1'b1;
    end
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] pop_byte();
    logic [BYTE_W-1:0] b;
    b = '0;
    if (bytes_used != 0) begin
      b = byte_ring[byte_rd];
      byte_rd = byte_rd + 1'b1;
      bytes_used = bytes_used - 1'b1;
    end
    return b;
  endfunction

  function automatic void load_next_head();
    if (lens_used != 0) head_left = pop_length();
    else no_head = 1'b1;
  endfunction

  function automatic result_t snapshot(input logic status, input logic [BYTE_W-1:0] b,
                                       input logic last, input logic [LEN_W-1:0] clen);
    result_t r;
    r.status    = status;
    r.data      = b;
    r.last      = last;
    r.chap_len  = clen;
    r.head_len  = head_left;
    r.chap_cnt  = CHAP_W'(stored_chapters());
    r.data_free = FREE_W'(DEPTH - int'(bytes_used));
    r.rec_free  = RFREE_W'(RDEPTH - int'(lens_used));
    return r;
  endfunction

  // Advances the chapter FIFO state by one operation and leaves the results
  // that it causes in step_results.
  task automatic chapter_fifo_step(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                                   input logic [CNT_W-1:0] cnt);
    logic              ok;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] chap_bytes [MAX_BURST];
    logic [LEN_W-1:0]  clen;
    int                n;
    int                total;
    ok = 1'b0;
    step_results.delete();
    case (op)
      OP_WRITE: begin
        if (lens_used < RDEPTH && bytes_used < DEPTH) begin
          byte_ring[byte_wr] = din;
          byte_wr = byte_wr + 1'b1;
          bytes_used = bytes_used + 1'b1;
          tail_len = tail_len + 1'b1;
          ok = 1'b1;
        end
      end
      OP_END: begin
        if (tail_len != 0 && lens_used < RDEPTH) begin
          len_ring[len_wr] = tail_len;
          len_wr = len_wr + 1'b1;
          lens_used = lens_used + 1'b1;
          if (no_head) begin
            head_left = pop_length();
            no_head = 1'b0;
          end
          tail_len = '0;
          ok = 1'b1;
        end
      end
      OP_RBYTE: begin
        if (head_left != 0) begin
          b = pop_byte();
          head_left = head_left - 1'b1;
          if (head_left == 0) load_next_head();
          step_results.push_back(snapshot(1'b0, b, 1'b1, '0));
          return;
        end
      end
      OP_RCHAP: begin
        if (head_left != 0) begin
          n = head_left > MAX_BURST ? MAX_BURST : int'(head_left);
          clen = head_left;
          for (int i = 0; i < n; i++) chap_bytes[i] = pop_byte();
          head_left = '0;
          load_next_head();
          for (int i = 0; i < n; i++)
            step_results.push_back(snapshot(1'b0, chap_bytes[i], i + 1 == n, clen));
          return;
        end
      end
      OP_DELETE: begin
        if (cnt != 0 && int'(cnt) <= stored_chapters()) begin
          total = head_left;
          for (int i = 0; i + 1 < int'(cnt); i++) total += pop_length();
          if (total > bytes_used) total = bytes_used;
          byte_rd = byte_rd + PTR_W'(total);
          bytes_used = bytes_used - LEN_W'(total);
          head_left = '0;
          load_next_head();
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    step_results.push_back(snapshot(!ok, '0, 1'b1, '0));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One operation on the input stream. The predictor runs at the transfer;
  // a pinned row queues its typed-in result instead of the predicted one.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                         input logic [CNT_W-1:0] cnt, input logic pinned,
                         input result_t want, input bit no_gap);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - BYTE_W - CNT_W){1'b0}}, cnt, din};
    do @(posedge clk); while (!in_tready);
    chapter_fifo_step(op, din, cnt);
    if (pinned) due_results.push_back(want);
    else foreach (step_results[i]) due_results.push_back(step_results[i]);
    sent_items++;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (due_results.size() != 0) @(posedge clk);
  endtask

  function automatic drow_t row(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                                input logic [CNT_W-1:0] cnt);
    drow_t d;
    d = '0;
    d.op  = op;
    d.din = din;
    d.cnt = cnt;
    return d;
  endfunction

  function automatic drow_t pin(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                                input logic [CNT_W-1:0] cnt, input logic status,
                                input int head, input int chaps, input int dfree,
                                input int rfree);
    drow_t d;
    d = row(op, din, cnt);
    d.pinned         = 1'b1;
    d.want.status    = status;
    d.want.last      = 1'b1;
    d.want.head_len  = LEN_W'(head);
    d.want.chap_cnt  = CHAP_W'(chaps);
    d.want.data_free = FREE_W'(dfree);
    d.want.rec_free  = RFREE_W'(rfree);
    return d;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.status    = out_tuser;
      seen.data      = out_tdata[7:0];
      seen.last      = out_tlast;
      seen.chap_len  = out_tdata[14:8];
      seen.head_len  = out_tdata[21:15];
      seen.chap_cnt  = out_tdata[26:22];
      seen.data_free = out_tdata[33:27];
      seen.rec_free  = out_tdata[38:34];
      if (due_results.size() == 0) begin
        note_mismatch("unexpected result, status", seen.status, 0);
      end else begin
        want = due_results.pop_front();
        if (seen.status !== want.status) note_mismatch("status", seen.status, want.status);
        if (seen.data !== want.data) note_mismatch("data_out", seen.data, want.data);
        if (seen.last !== want.last) note_mismatch("last", seen.last, want.last);
        if (seen.chap_len !== want.chap_len)
          note_mismatch("chapter_length", seen.chap_len, want.chap_len);
        if (seen.head_len !== want.head_len)
          note_mismatch("head_length", seen.head_len, want.head_len);
        if (seen.chap_cnt !== want.chap_cnt)
          note_mismatch("chapter_count", seen.chap_cnt, want.chap_cnt);
        if (seen.data_free !== want.data_free)
          note_mismatch("data_free", seen.data_free, want.data_free);
        if (seen.rec_free !== want.rec_free)
          note_mismatch("record_free", seen.rec_free, want.rec_free);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: runs of ready with stalls between them, now and then a long run.
  initial begin
    int run;
    out_tready <= 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      run = pick_gap();
      if (run > 0) begin
        out_tready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    int     r;
    int     len;
    int     k;
    bit     calm;
    logic [CNT_W-1:0] dc;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    byte_rd    = '0;
    byte_wr    = '0;
    bytes_used = '0;
    len_rd     = '0;
    len_wr     = '0;
    lens_used  = '0;
    head_left  = '0;
    tail_len   = '0;
    no_head    = 1'b1;

    // Refusals on an empty FIFO, then a few small chapters.
    plan[0]  = pin(OP_RBYTE,  8'h00, 5'd0,  1'b1, 0, 0, 64, 16);
    plan[1]  = pin(OP_RCHAP,  8'h00, 5'd0,  1'b1, 0, 0, 64, 16);
    plan[2]  = pin(OP_END,    8'h00, 5'd0,  1'b1, 0, 0, 64, 16);
    plan[3]  = pin(OP_DELETE, 8'h00, 5'd0,  1'b1, 0, 0, 64, 16);
    plan[4]  = pin(OP_DELETE, 8'h00, 5'd1,  1'b1, 0, 0, 64, 16);
    plan[5]  = pin(OP_RSVD5,  8'hFF, 5'h1F, 1'b1, 0, 0, 64, 16);
    plan[6]  = pin(OP_RSVD6,  8'h55, 5'h0A, 1'b1, 0, 0, 64, 16);
    plan[7]  = pin(OP_RSVD7,  8'hAA, 5'h15, 1'b1, 0, 0, 64, 16);
    plan[8]  = pin(OP_WRITE,  8'h00, 5'd0,  1'b0, 0, 0, 63, 16);
    plan[9]  = pin(OP_WRITE,  8'hFF, 5'h1F, 1'b0, 0, 0, 62, 16);
    plan[10] = pin(OP_END,    8'h00, 5'd0,  1'b0, 2, 1, 62, 16);
    plan[11] = pin(OP_WRITE,  8'hA5, 5'd0,  1'b0, 2, 1, 61, 16);
    plan[12] = pin(OP_END,    8'h00, 5'd0,  1'b0, 2, 2, 61, 15);
    plan[13] = pin(OP_END,    8'h00, 5'd0,  1'b1, 2, 2, 61, 15);
    plan[14] = row(OP_RBYTE,  8'h00, 5'd0);
    plan[15] = row(OP_RBYTE,  8'h00, 5'd0);
    plan[16] = row(OP_WRITE,  8'h3C, 5'd0);
    plan[17] = row(OP_WRITE,  8'hC3, 5'd0);
    plan[18] = row(OP_END,    8'h00, 5'd0);
    plan[19] = row(OP_RCHAP,  8'h00, 5'd0);
    plan[20] = row(OP_WRITE,  8'h81, 5'd0);
    plan[21] = row(OP_END,    8'h00, 5'd0);
    plan[22] = pin(OP_DELETE, 8'h00, 5'd3,  1'b1, 2, 2, 61, 15);
    plan[23] = pin(OP_DELETE, 8'h00, 5'd2,  1'b0, 0, 0, 64, 16);
    plan[24] = pin(OP_RCHAP,  8'h00, 5'd0,  1'b1, 0, 0, 64, 16);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++)
      send_op(plan[i].op, plan[i].din, plan[i].cnt, plan[i].pinned, plan[i].want, 1'b0);

    // Hold the sender off until the directed results have all come back.
    in_tvalid <= 1'b0;
    wait_drained();

    k = 0;
    while (sent_items < N_ROWS + RANDOM_ITEMS) begin
      r    = $urandom_range(0, 99);
      calm = ($urandom_range(0, 4) == 0);
      if (k == 0 || (k > 1 && r >= 90 && r < 93)) begin
        // Up to DEPTH + 2 bytes in one chapter, overrunning a full data ring.
        len = (k == 0) ? DEPTH + 2 : $urandom_range(41, DEPTH + 2);
        repeat (len) send_op(OP_WRITE, 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
        send_op(OP_END, 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
        send_op(OP_RCHAP, 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
      end else if (k == 1 || (r >= 93 && r < 95)) begin
        // Single-byte chapters until the length ring refuses further writes.
        repeat (RDEPTH + 2) begin
          send_op(OP_WRITE, 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
          send_op(OP_END, 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
        end
        dc = CNT_W'(stored_chapters());
        send_op(OP_DELETE, 8'($urandom()), dc, 1'b0, '0, calm);
      end else if (r < 35) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        repeat (len) send_op(OP_WRITE, 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
        if ($urandom_range(0, 9) != 0)
          send_op(OP_END, 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
      end else if (r < 55) begin
        repeat ($urandom_range(1, 4))
          send_op(OP_RBYTE, 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
      end else if (r < 70) begin
        send_op(OP_RCHAP, 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
      end else if (r < 80) begin
        if ($urandom_range(0, 9) < 7)
          dc = CNT_W'($urandom_range(1, stored_chapters() > 0 ? stored_chapters() : 1));
        else
          dc = 5'($urandom());
        send_op(OP_DELETE, 8'($urandom()), dc, 1'b0, '0, calm);
      end else if (r < 85) begin
        send_op(3'($urandom()), 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
      end else if (r < 90) begin
        send_op(OP_END, 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
      end else if (r < 97) begin
        in_tvalid <= 1'b0;
        wait_drained();
      end else begin
        repeat (2) send_op(OP_RCHAP, 8'($urandom()), 5'($urandom()), 1'b0, '0, calm);
      end
      k++;
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cfbf_pkg.sv
src/cfbf_ram.sv
src/cfbf_ctrl.sv
src/cfbf_dp.sv
src/chaptered_byte_fifo_core.sv
verif/tb_top.sv
